// ----- rtl/core/decimal_seven_segment_scan_top_defines.svh -----
// Assertion macros used by the display scan top level.
`ifndef DECIMAL_SEVEN_SEGMENT_SCAN_TOP_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_SCAN_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define DSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define DSS_ASSERT_IMPL(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

// ----- rtl/core/dss_pkg.sv -----
// Types, constants and lookup functions for the decimal display scan.
package dss_pkg;

    localparam int VALUE_W   = 27;
    localparam int SEL_W     = 3;
    localparam int SEG_W     = 8;
    localparam int DIGIT_W   = 4;
    localparam int POSITIONS = 8;
    localparam int RADIX     = 10;

    localparam logic [VALUE_W-1:0] DEC_LIMIT = 27'd100000000;
    localparam logic [SEL_W-1:0]   LAST_POS  = 3'd7;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [DIGIT_W-1:0] t_digit;

    // One digit beat leaving the scan unit.
    typedef struct packed {
        logic             valid;
        logic [SEL_W-1:0] sel;
        logic [SEG_W-1:0] pattern;
        logic             last;
    } t_beat;

    // Place value of a scan position: 10^(7 - pos).
    function automatic t_value dss_pow10(input logic [SEL_W-1:0] pos);
        t_value r;
        unique case (pos)
            3'd0:    r = 27'd10000000;
            3'd1:    r = 27'd1000000;
            3'd2:    r = 27'd100000;
            3'd3:    r = 27'd10000;
            3'd4:    r = 27'd1000;
            3'd5:    r = 27'd100;
            3'd6:    r = 27'd10;
            default: r = 27'd1;
        endcase
        return r;
    endfunction

    // Common-cathode pattern, segment a in bit 0, point always dark.
    function automatic logic [SEG_W-1:0] dss_seg(input t_digit d);
        logic [SEG_W-1:0] r;
        unique case (d)
            4'd0:    r = 8'h3f;
            4'd1:    r = 8'h06;
            4'd2:    r = 8'h5b;
            4'd3:    r = 8'h4f;
            4'd4:    r = 8'h66;
            4'd5:    r = 8'h6d;
            4'd6:    r = 8'h7d;
            4'd7:    r = 8'h07;
            4'd8:    r = 8'h7f;
            4'd9:    r = 8'h6f;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/dss_in_reg.sv -----
// Input holding register: folds the value below 10^8 and waits for the scan unit.
module dss_in_reg import dss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_take,
    output logic               o_valid,
    output logic [VALUE_W-1:0] o_value
);

    logic         r_valid;
    t_value       r_value;
    t_value       n_value;
    logic         w_accept;

    assign o_s_tready = !r_valid;
    assign w_accept   = i_s_tvalid && !r_valid;

    // Values up to 2^27-1 stay below 2 * 10^8, so one subtract drops the high digits.
    assign n_value = (i_value >= DEC_LIMIT) ? (i_value - DEC_LIMIT) : i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= n_value;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

// ----- rtl/core/dss_scan.sv -----
// Digit scan unit: peels one decimal digit per cycle while the output is free, most significant first.
module dss_scan import dss_pkg::*; #(
    parameter int FIRST_POS = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load_valid,
    input  logic [VALUE_W-1:0] i_load_value,
    output logic               o_load_take,
    input  logic               i_out_free,
    output t_beat              o_beat
);

    logic             r_busy;
    logic [SEL_W-1:0] r_pos;
    t_value           r_rem;
    t_value           n_rem;
    t_value           w_pow;
    t_value           w_thr [RADIX];
    logic [RADIX-2:0] w_ge;
    t_digit           w_digit;
    logic             w_advance;
    logic             w_done;
    logic             w_take;

    assign w_advance = r_busy && i_out_free;
    assign w_done    = w_advance && (r_pos == LAST_POS);
    assign w_take    = i_load_valid && (!r_busy || w_done);

    // Digit is the count of multiples of the place value not above the remainder.
    always_comb begin
        w_pow = dss_pow10(r_pos);
        for (int d = 0; d < RADIX; d++) begin
            w_thr[d] = w_pow * VALUE_W'(d);
        end
        for (int d = 1; d < RADIX; d++) begin
            w_ge[d-1] = (r_rem >= w_thr[d]);
        end
        w_digit = DIGIT_W'($countones(w_ge));
        n_rem   = r_rem - w_thr[w_digit];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_take) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_take) begin
            r_pos <= '0;
        end else if (w_advance) begin
            r_pos <= r_pos + SEL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rem <= i_load_value;
        end else if (w_advance) begin
            r_rem <= n_rem;
        end
    end

    // Positions ahead of the first shown one are peeled without a beat.
    assign o_beat.valid   = w_advance && (r_pos >= SEL_W'(FIRST_POS));
    assign o_beat.sel     = r_pos;
    assign o_beat.pattern = dss_seg(w_digit);
    assign o_beat.last    = (r_pos == LAST_POS);
    assign o_load_take    = w_take;

endmodule

// ----- rtl/core/decimal_seven_segment_scan_top.sv -----
// Multiplexed eight-digit decimal seven-segment display scan, top level.
// Each value beat on the slave side becomes DIGIT_COUNT digit beats on the master side, one
// per driven position from 8 - DIGIT_COUNT up to 7, most significant first; the beat of
// position 7 carries tlast. Values of 10^8 or more show their low eight digits. The scan
// unit peels one decimal digit per cycle through all eight positions while the output
// register is free, so a value occupies it for all eight positions whatever DIGIT_COUNT is,
// and it takes the next value as it finishes position 7. The input register holds the
// next value during a scan and the output register holds each digit beat, so the first
// beat of a value passes the input, remainder and output registers and hidden positions.
module decimal_seven_segment_scan_top import dss_pkg::*; #(
    parameter int DIGIT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [26:0] display_value, [31:27] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] segment_pattern
    output logic [2:0]  o_m_tuser,   // [2:0] digit_select
    output logic        o_m_tlast    // last_digit
);

    `include "decimal_seven_segment_scan_top_defines.svh"

    localparam int DIGITS    = (DIGIT_COUNT < 1) ? 1 :
                               ((DIGIT_COUNT > POSITIONS) ? POSITIONS : DIGIT_COUNT);
    localparam int FIRST_POS = POSITIONS - DIGITS;
    localparam logic [SEL_W-1:0] FIRST_SEL = SEL_W'(FIRST_POS);

    logic             w_buf_valid;
    t_value           w_buf_value;
    logic             w_take;
    logic             w_out_free;
    t_beat            w_beat;

    logic             r_out_valid;
    logic [SEL_W-1:0] r_out_sel;
    logic [SEG_W-1:0] r_out_pat;
    logic             r_out_last;

    dss_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_value    (i_s_tdata[VALUE_W-1:0]),
        .i_take     (w_take),
        .o_valid    (w_buf_valid),
        .o_value    (w_buf_value)
    );

    dss_scan #(
        .FIRST_POS (FIRST_POS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (w_buf_valid),
        .i_load_value (w_buf_value),
        .o_load_take  (w_take),
        .i_out_free   (w_out_free),
        .o_beat       (w_beat)
    );

    // Advance the scan only when the output register can take the beat.
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_beat.valid) begin
            r_out_sel  <= w_beat.sel;
            r_out_pat  <= w_beat.pattern;
            r_out_last <= w_beat.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pat;
    assign o_m_tuser  = r_out_sel;
    assign o_m_tlast  = r_out_last;

    `DSS_ASSERT_IMPL(a_last_sel, o_m_tvalid && o_m_tlast, o_m_tuser == LAST_POS, "last beat off position 7")
    `DSS_ASSERT_IMPL(a_sel_shown, o_m_tvalid, o_m_tuser >= FIRST_SEL, "beat for a hidden position")
    `DSS_ASSERT_IMPL(a_point_dark, o_m_tvalid, o_m_tdata[SEG_W-1] == 1'b0, "decimal point lit")
    `DSS_ASSERT(a_take_busy, w_take |-> w_buf_valid, "scan loaded from an empty buffer")

endmodule

// ----- dv/tb_decimal_seven_segment_scan_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the eight-digit decimal seven-segment display scan.
module tb_decimal_seven_segment_scan_top;
    import dss_pkg::*;

    localparam int SCAN_DIGITS = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 24;
    localparam int RANDOM_VALUES = 200;
    localparam int DIRECTED_COUNT = 16;

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic [SEG_W-1:0] pattern;
        logic             last;
    } t_digit_beat;

    // Digit beats each accepted value should produce, oldest first.
    class digit_beat_ledger;
        t_digit_beat pending_digits[$];
        int          mismatches;
        int          digits_seen;
        int          values_taken;

        function new();
            mismatches   = 0;
            digits_seen  = 0;
            values_taken = 0;
        endfunction

        function logic [SEG_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
            logic [SEG_W-1:0] g;
            case (d)
                4'd0:    g = 8'h3f;
                4'd1:    g = 8'h06;
                4'd2:    g = 8'h5b;
                4'd3:    g = 8'h4f;
                4'd4:    g = 8'h66;
                4'd5:    g = 8'h6d;
                4'd6:    g = 8'h7d;
                4'd7:    g = 8'h07;
                4'd8:    g = 8'h7f;
                default: g = 8'h6f;
            endcase
            return g;
        endfunction

        task report(input string msg);
            mismatches++;
            $display("%0t MISMATCH: %s", $time, msg);
        endtask

        // Split into decimal digits, most significant first; anything above 10^8 wraps.
        task note_value(input t_value v);
            int unsigned       rest;
            logic [DIGIT_W-1:0] digit [POSITIONS];
            int                count;
            t_digit_beat       b;
            rest  = v;
            count = (SCAN_DIGITS < 1) ? 1 : ((SCAN_DIGITS > POSITIONS) ? POSITIONS : SCAN_DIGITS);
            for (int p = POSITIONS - 1; p >= 0; p--) begin
                digit[p] = DIGIT_W'(rest % RADIX);
                rest     = rest / RADIX;
            end
            for (int p = POSITIONS - count; p < POSITIONS; p++) begin
                b.sel     = SEL_W'(p);
                b.pattern = glyph_of(digit[p]);
                b.last    = (p == POSITIONS - 1);
                pending_digits.push_back(b);
            end
            values_taken++;
        endtask

        task check_digit(input logic [SEL_W-1:0] sel, input logic [SEG_W-1:0] pattern,
                         input logic last);
            t_digit_beat want;
            digits_seen++;
            if (pending_digits.size() == 0) begin
                report($sformatf("unexpected digit beat sel=%0d pattern=%02h last=%0b",
                                 sel, pattern, last));
                return;
            end
            want = pending_digits.pop_front();
            if (sel !== want.sel)
                report($sformatf("beat %0d sel=%0d, want %0d", digits_seen, sel, want.sel));
            if (pattern !== want.pattern)
                report($sformatf("beat %0d pattern=%02h, want %02h", digits_seen, pattern,
                                 want.pattern));
            if (last !== want.last)
                report($sformatf("beat %0d last=%0b, want %0b", digits_seen, last, want.last));
        endtask

        task close_out();
            if (pending_digits.size() != 0)
                report($sformatf("%0d digit beats never arrived", pending_digits.size()));
        endtask
    endclass

    logic               i_clk;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [31:0]        s_tdata  = '0;   // [26:0] display_value, [31:27] zero
    logic               m_tready = 1'b0;
    logic               o_s_tready;
    logic               o_m_tvalid;
    logic [SEG_W-1:0]   o_m_tdata;       // [7:0] segment_pattern
    logic [SEL_W-1:0]   o_m_tuser;       // [2:0] digit_select
    logic               o_m_tlast;

    digit_beat_ledger   ledger;
    int                 stall_pct   = 0;
    int                 stall_left  = 0;
    int                 cycle_count = 0;

    t_value directed_values [DIRECTED_COUNT] = '{
        27'd0, 27'd99999999, 27'd100000000, 27'h7ffffff, 27'd12345678, 27'd87654321,
        27'd10000000, 27'd1, 27'd9, 27'd10, 27'd90909090, 27'd55555555,
        27'h5555555, 27'h2aaaaaa, 27'd100000001, 27'd34567890
    };

    decimal_seven_segment_scan_top #(
        .DIGIT_COUNT(SCAN_DIGITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        else if (r < 85) return $urandom_range(3, 1);
        else if (r < 97) return $urandom_range(12, 4);
        else return $urandom_range(60, 20);
    endfunction

    function automatic t_value pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40) return t_value'($urandom);
        else if (r < 70) return t_value'($urandom_range(99999999, 0));
        else if (r < 85) return t_value'($urandom_range(999, 0));
        else return t_value'($urandom_range(100000020, 99999980));
    endfunction

    // Hold the beat until the block takes it; valid stays high for a back-to-back beat.
    task automatic send_value(input t_value v, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, v};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        ledger.note_value(v);
    endtask

    // Sink side: check every accepted digit beat, then pick the next ready.
    always @(posedge i_clk) begin
        if (rst_n && o_m_tvalid === 1'b1 && m_tready)
            ledger.check_digit(o_m_tuser, o_m_tdata, o_m_tlast);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int phase;
        ledger = new();
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, wrap at 10^8, every digit, back to back.
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_value(directed_values[i], 0);

        for (int i = 0; i < RANDOM_VALUES; i++) begin
            phase = i / (RANDOM_VALUES / 4);
            stall_pct = (phase == 0) ? 0 : ((phase == 1) ? 40 : 15);
            if (i == RANDOM_VALUES / 2) begin
                // Drain everything before going on.
                s_tvalid <= 1'b0;
                do @(posedge i_clk); while (ledger.pending_digits.size() != 0);
            end
            send_value(pick_value(), (phase == 0) ? 0 : pick_gap());
        end
        s_tvalid <= 1'b0;

        do @(posedge i_clk); while (ledger.pending_digits.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        ledger.close_out();

        $display("covered %0d values: extremes, wrap past 10^8, full 27-bit random range",
                 ledger.values_taken);
        $display("checked %0d digit beats under random source gaps and sink stalls",
                 ledger.digits_seen);
        if (ledger.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
